// ===== sv/tlbe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlbe_pkg;

    // Default widths of a coordinate and of a corner label.
    localparam int unsigned TLBE_COORD_BITS = 32;
    localparam int unsigned TLBE_LABEL_BITS = 32;

    // Quotient bits resolved per register stage of the divide-by-three pipe.
    localparam int unsigned TLBE_DIV_STEPS = 8;

    // Segment slots of one triangle: three mesh edges and up to three borders.
    localparam int unsigned TLBE_NUM_SLOTS = 6;

    // Configuration port geometry.
    localparam int unsigned TLBE_APB_AW = 3;
    localparam int unsigned TLBE_APB_DW = 32;

    // Register index, taken from paddr[2].
    localparam logic TLBE_REG_MESH = 1'b0;

    typedef enum logic [1:0] {
        KIND_MESH    = 2'd0,
        KIND_MID_MID = 2'd1,
        KIND_MID_CTR = 2'd2
    } t_seg_kind;

    // How the corner labels split the triangle.
    typedef enum logic [2:0] {
        BORDER_NONE = 3'd0,
        BORDER_ALL  = 3'd1,
        BORDER_A    = 3'd2,
        BORDER_B    = 3'd3,
        BORDER_C    = 3'd4
    } t_border;

    typedef enum logic [2:0] {
        SLOT_AB   = 3'd0,
        SLOT_AC   = 3'd1,
        SLOT_BC   = 3'd2,
        SLOT_BRD0 = 3'd3,
        SLOT_BRD1 = 3'd4,
        SLOT_BRD2 = 3'd5
    } t_slot;

endpackage

`default_nettype wire

// ===== sv/tlbe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tlbe_tri_if import tlbe_pkg::*; #(
    parameter int unsigned COORD_BITS = TLBE_COORD_BITS,
    parameter int unsigned LABEL_BITS = TLBE_LABEL_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] corner_a_x;
    logic signed [COORD_BITS-1:0] corner_a_y;
    logic signed [COORD_BITS-1:0] corner_a_z;
    logic signed [COORD_BITS-1:0] corner_b_x;
    logic signed [COORD_BITS-1:0] corner_b_y;
    logic signed [COORD_BITS-1:0] corner_b_z;
    logic signed [COORD_BITS-1:0] corner_c_x;
    logic signed [COORD_BITS-1:0] corner_c_y;
    logic signed [COORD_BITS-1:0] corner_c_z;
    logic        [LABEL_BITS-1:0] label_a;
    logic        [LABEL_BITS-1:0] label_b;
    logic        [LABEL_BITS-1:0] label_c;

    modport source (
        output valid, corner_a_x, corner_a_y, corner_a_z,
               corner_b_x, corner_b_y, corner_b_z,
               corner_c_x, corner_c_y, corner_c_z,
               label_a, label_b, label_c,
        input  ready
    );

    modport sink (
        input  valid, corner_a_x, corner_a_y, corner_a_z,
               corner_b_x, corner_b_y, corner_b_z,
               corner_c_x, corner_c_y, corner_c_z,
               label_a, label_b, label_c,
        output ready
    );
endinterface

interface tlbe_seg_if import tlbe_pkg::*; #(
    parameter int unsigned COORD_BITS = TLBE_COORD_BITS
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_z;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_z;
    logic        [1:0]            segment_kind;
    logic                         last_segment;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               segment_kind, last_segment,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               segment_kind, last_segment,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/tlbe_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two stages: input capture with label classification, then edge midpoints
// and the biased corner sum that feeds the divide-by-three pipe.
module tlbe_prep import tlbe_pkg::*; #(
    parameter int unsigned COORD_BITS = TLBE_COORD_BITS,
    parameter int unsigned LABEL_BITS = TLBE_LABEL_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic [2:0][COORD_BITS-1:0]       i_a,
    input  logic [2:0][COORD_BITS-1:0]       i_b,
    input  logic [2:0][COORD_BITS-1:0]       i_c,
    input  logic [LABEL_BITS-1:0]            i_la,
    input  logic [LABEL_BITS-1:0]            i_lb,
    input  logic [LABEL_BITS-1:0]            i_lc,
    output logic                             o_valid,
    output logic [2:0][COORD_BITS-1:0]       o_a,
    output logic [2:0][COORD_BITS-1:0]       o_b,
    output logic [2:0][COORD_BITS-1:0]       o_c,
    output logic [2:0][COORD_BITS-1:0]       o_mab,
    output logic [2:0][COORD_BITS-1:0]       o_mac,
    output logic [2:0][COORD_BITS-1:0]       o_mbc,
    output logic [2:0][COORD_BITS+1:0]       o_u,
    output t_border                          o_border
);
    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned W  = COORD_BITS + 2;
    // The bias makes the sum of three corners plus one strictly positive.
    localparam logic [W-1:0] U_BIAS = (W'(3) << (CB - 1)) + W'(1);

    logic                r_s1_valid;
    logic [2:0][CB-1:0]  r_s1_a, r_s1_b, r_s1_c;
    t_border             r_s1_border;
    t_border             n_s1_border;

    logic                r_s2_valid;
    logic [2:0][CB-1:0]  r_s2_a, r_s2_b, r_s2_c;
    logic [2:0][CB-1:0]  r_s2_mab, r_s2_mac, r_s2_mbc;
    logic [2:0][W-1:0]   r_s2_u;
    t_border             r_s2_border;

    logic [2:0][CB:0]    w_sab, w_sac, w_sbc;
    logic [2:0][W-1:0]   w_u;
    logic                w_eq_ab, w_eq_ac, w_eq_bc;

    always_comb begin
        w_eq_ab = (i_la == i_lb);
        w_eq_ac = (i_la == i_lc);
        w_eq_bc = (i_lb == i_lc);
        if (w_eq_ab && w_eq_bc) begin
            n_s1_border = BORDER_NONE;
        end else if (!w_eq_ab && !w_eq_ac && !w_eq_bc) begin
            n_s1_border = BORDER_ALL;
        end else if (!w_eq_ab && !w_eq_ac) begin
            n_s1_border = BORDER_A;
        end else if (!w_eq_ab && !w_eq_bc) begin
            n_s1_border = BORDER_B;
        end else begin
            n_s1_border = BORDER_C;
        end
    end

    // Midpoints are the pair sum shifted right arithmetically (floor).
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sab[k] = {r_s1_a[k][CB-1], r_s1_a[k]} + {r_s1_b[k][CB-1], r_s1_b[k]};
            w_sac[k] = {r_s1_a[k][CB-1], r_s1_a[k]} + {r_s1_c[k][CB-1], r_s1_c[k]};
            w_sbc[k] = {r_s1_b[k][CB-1], r_s1_b[k]} + {r_s1_c[k][CB-1], r_s1_c[k]};
            w_u[k]   = {{2{r_s1_a[k][CB-1]}}, r_s1_a[k]}
                     + {{2{r_s1_b[k][CB-1]}}, r_s1_b[k]}
                     + {{2{r_s1_c[k][CB-1]}}, r_s1_c[k]}
                     + U_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_a      <= i_a;
            r_s1_b      <= i_b;
            r_s1_c      <= i_c;
            r_s1_border <= n_s1_border;
            r_s2_a      <= r_s1_a;
            r_s2_b      <= r_s1_b;
            r_s2_c      <= r_s1_c;
            r_s2_border <= r_s1_border;
            r_s2_u      <= w_u;
            for (int k = 0; k < 3; k++) begin
                r_s2_mab[k] <= w_sab[k][CB:1];
                r_s2_mac[k] <= w_sac[k][CB:1];
                r_s2_mbc[k] <= w_sbc[k][CB:1];
            end
        end
    end

    assign o_valid  = r_s2_valid;
    assign o_a      = r_s2_a;
    assign o_b      = r_s2_b;
    assign o_c      = r_s2_c;
    assign o_mab    = r_s2_mab;
    assign o_mac    = r_s2_mac;
    assign o_mbc    = r_s2_mbc;
    assign o_u      = r_s2_u;
    assign o_border = r_s2_border;

endmodule

`default_nettype wire

// ===== sv/tlbe_div3.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring division by three on three lanes, a fixed number of quotient
// bits per stage, with a side payload that travels alongside.
module tlbe_div3 import tlbe_pkg::*; #(
    parameter int unsigned W  = TLBE_COORD_BITS + 2,
    parameter int unsigned PW = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [2:0][W-1:0]    i_num,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_valid,
    output logic [2:0][W-1:0]    o_quo,
    output logic [PW-1:0]        o_pay
);
    localparam int unsigned NST = (W + TLBE_DIV_STEPS - 1) / TLBE_DIV_STEPS;
    localparam int unsigned WP  = NST * TLBE_DIV_STEPS;

    logic [NST-1:0]        r_v;
    logic [2:0][WP-1:0]    r_x   [NST];
    logic [2:0][1:0]       r_rem [NST-1];
    logic [PW-1:0]         r_pay [NST];

    // The dividend shifts out at the top while quotient bits shift in below.
    function automatic logic [WP+1:0] f_div_steps(input logic [WP-1:0] x,
                                                   input logic [1:0] rem);
        logic [WP-1:0] xv;
        logic [1:0]    rv;
        logic [2:0]    t;
        xv = x;
        rv = rem;
        for (int i = 0; i < TLBE_DIV_STEPS; i++) begin
            t = {rv, xv[WP-1]};
            if (t >= 3'd3) begin
                rv = 2'(t - 3'd3);
                xv = {xv[WP-2:0], 1'b1};
            end else begin
                rv = t[1:0];
                xv = {xv[WP-2:0], 1'b0};
            end
        end
        return {rv, xv};
    endfunction

    for (genvar s = 0; s < NST; s++) begin : g_stage
        logic [2:0][WP-1:0] w_xin;
        logic [2:0][1:0]    w_rin;
        logic [2:0][WP+1:0] w_res;
        logic [PW-1:0]      w_pin;

        if (s == 0) begin : g_first
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign w_xin[k] = WP'(i_num[k]);
            end
            assign w_rin = '0;
            assign w_pin = i_pay;
        end else begin : g_next
            assign w_xin = r_x[s-1];
            assign w_rin = r_rem[s-1];
            assign w_pin = r_pay[s-1];
        end

        always_comb begin
            for (int k = 0; k < 3; k++) begin
                w_res[k] = f_div_steps(w_xin[k], w_rin[k]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pay[s] <= w_pin;
                for (int k = 0; k < 3; k++) begin
                    r_x[s][k] <= w_res[k][WP-1:0];
                end
            end
        end

        if (s < NST - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    for (int k = 0; k < 3; k++) begin
                        r_rem[s][k] <= w_res[k][WP+1:WP];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_pay   = r_pay[NST-1];
    for (genvar k = 0; k < 3; k++) begin : g_out
        assign o_quo[k] = r_x[NST-1][k][W-1:0];
    end

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en && o_valid |=> o_valid && $stable(o_pay))
        else $error("divider pipe dropped or changed an item while stalled");

endmodule

`default_nettype wire

// ===== sv/tlbe_emit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Holds one triangle and sends its segments, one per beat, through an
// output register. A mask of pending slots drives the sequence.
module tlbe_emit import tlbe_pkg::*; #(
    parameter int unsigned COORD_BITS = TLBE_COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_take,
    input  logic                        i_mesh,
    input  logic [2:0][COORD_BITS-1:0]  i_a,
    input  logic [2:0][COORD_BITS-1:0]  i_b,
    input  logic [2:0][COORD_BITS-1:0]  i_c,
    input  logic [2:0][COORD_BITS-1:0]  i_mab,
    input  logic [2:0][COORD_BITS-1:0]  i_mac,
    input  logic [2:0][COORD_BITS-1:0]  i_mbc,
    input  logic [2:0][COORD_BITS-1:0]  i_ctr,
    input  t_border                     i_border,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0][COORD_BITS-1:0]  o_start,
    output logic [2:0][COORD_BITS-1:0]  o_end,
    output t_seg_kind                   o_kind,
    output logic                        o_last
);
    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned NS = TLBE_NUM_SLOTS;

    logic [NS-1:0]        r_mask;
    logic [NS-1:0]        n_mask;
    logic [2:0][CB-1:0]   r_a, r_b, r_c, r_mab, r_mac, r_mbc, r_ctr;
    t_border              r_border;

    logic                 r_ovalid;
    logic [2:0][CB-1:0]   r_start, r_end;
    t_seg_kind            r_kind;
    logic                 r_last;

    logic [NS-1:0]        w_low, w_rest;
    t_slot                w_slot;
    logic [2:0][CB-1:0]   w_start, w_end;
    t_seg_kind            w_kind;
    logic                 w_seg_load;
    logic                 w_take;

    always_comb begin
        w_low  = r_mask & (~r_mask + NS'(1));
        w_rest = r_mask & ~w_low;
        w_slot = SLOT_AB;
        for (int i = NS - 1; i >= 0; i--) begin
            if (w_low[i]) begin
                w_slot = t_slot'(3'(i));
            end
        end
    end

    always_comb begin
        w_start = r_a;
        w_end   = r_b;
        w_kind  = KIND_MESH;
        case (w_slot)
            SLOT_AB: begin
                w_start = r_a;
                w_end   = r_b;
            end
            SLOT_AC: begin
                w_start = r_a;
                w_end   = r_c;
            end
            SLOT_BC: begin
                w_start = r_b;
                w_end   = r_c;
            end
            SLOT_BRD0: begin
                case (r_border)
                    BORDER_ALL: begin
                        w_start = r_mab;
                        w_end   = r_ctr;
                        w_kind  = KIND_MID_CTR;
                    end
                    BORDER_A: begin
                        w_start = r_mab;
                        w_end   = r_mac;
                        w_kind  = KIND_MID_MID;
                    end
                    BORDER_B: begin
                        w_start = r_mab;
                        w_end   = r_mbc;
                        w_kind  = KIND_MID_MID;
                    end
                    default: begin
                        w_start = r_mac;
                        w_end   = r_mbc;
                        w_kind  = KIND_MID_MID;
                    end
                endcase
            end
            SLOT_BRD1: begin
                w_start = r_mac;
                w_end   = r_ctr;
                w_kind  = KIND_MID_CTR;
            end
            SLOT_BRD2: begin
                w_start = r_mbc;
                w_end   = r_ctr;
                w_kind  = KIND_MID_CTR;
            end
            default: begin
                w_start = r_a;
                w_end   = r_b;
            end
        endcase
    end

    always_comb begin
        n_mask            = '0;
        n_mask[SLOT_AB]   = i_mesh;
        n_mask[SLOT_AC]   = i_mesh;
        n_mask[SLOT_BC]   = i_mesh;
        n_mask[SLOT_BRD0] = (i_border != BORDER_NONE);
        n_mask[SLOT_BRD1] = (i_border == BORDER_ALL);
        n_mask[SLOT_BRD2] = (i_border == BORDER_ALL);
    end

    assign w_seg_load = (r_mask != '0) && (!r_ovalid || i_ready);
    assign w_take     = (r_mask == '0) || (w_seg_load && (w_rest == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // A new triangle is loaded only once the last beat leaves no slot pending.
            if (w_take && i_valid) begin
                r_mask <= n_mask;
            end else if (w_seg_load) begin
                r_mask <= w_rest;
            end
            if (w_seg_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_valid) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_c      <= i_c;
            r_mab    <= i_mab;
            r_mac    <= i_mac;
            r_mbc    <= i_mbc;
            r_ctr    <= i_ctr;
            r_border <= i_border;
        end
        if (w_seg_load) begin
            r_start <= w_start;
            r_end   <= w_end;
            r_kind  <= w_kind;
            r_last  <= (w_rest == '0);
        end
    end

    assign o_take  = w_take;
    assign o_valid = r_ovalid;
    assign o_start = r_start;
    assign o_end   = r_end;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

    a_ctr_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mask[SLOT_BRD1] |-> r_mask[SLOT_BRD2])
        else $error("centroid segments went out of order");

    a_ctr_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mask[SLOT_BRD1] |-> (r_border == BORDER_ALL))
        else $error("centroid segment pending for a triangle without three regions");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_kind == KIND_MID_MID) |-> r_last)
        else $error("midpoint-to-midpoint segment was not the final one");

endmodule

`default_nettype wire

// ===== sv/triangle_label_border_extract_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Modport         Beat carries
// i_tri     sink            three corners (x, y, z signed Q16.16) and three labels
// o_seg     source          one segment: start, end, kind, last-of-triangle flag
// APB       psel..prdata    emit_mesh_edges at byte address 0
//
// A triangle passes two preparation stages, ceil((COORD_BITS+2)/8) divider stages
// (five at the default width) and the emitter, whose slot mask and output register
// lie before o_seg. The emitter sends one segment per cycle while o_seg is ready,
// up to six per triangle. One shared advance signal stops every preparation and
// divider stage once the last divider stage waits on a busy emitter; nothing is lost.
// Reset is synchronous and active low; it clears valid bits and sets emit_mesh_edges.
module triangle_label_border_extract_core import tlbe_pkg::*; #(
    parameter int unsigned COORD_BITS = TLBE_COORD_BITS,
    parameter int unsigned LABEL_BITS = TLBE_LABEL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    tlbe_tri_if.sink                 i_tri,
    tlbe_seg_if.source               o_seg,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [TLBE_APB_AW-1:0]   paddr,
    input  logic [TLBE_APB_DW-1:0]   pwdata,
    output logic [TLBE_APB_DW-1:0]   prdata,
    output logic                     pready
);
    localparam int unsigned CB = COORD_BITS;
    localparam int unsigned W  = COORD_BITS + 2;
    // Side payload through the divider: corners, midpoints and the class.
    localparam int unsigned PW = 18 * COORD_BITS + $bits(t_border);
    localparam int unsigned BW = $bits(t_border);

    // The mesh-edge enable. Users write only while idle; the block does not check it.
    logic r_mesh;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mesh <= 1'b1;
        end else if (psel && penable && pwrite && (paddr[TLBE_APB_AW-1] == TLBE_REG_MESH)) begin
            r_mesh <= pwdata[0];
        end
    end

    assign prdata = (paddr[TLBE_APB_AW-1] == TLBE_REG_MESH)
                  ? {{(TLBE_APB_DW-1){1'b0}}, r_mesh} : '0;

    // One advance signal for the prep and divider stages: it moves whenever the last
    // divider stage is empty or the emitter takes its triangle.
    logic                w_en;
    logic                w_take;

    logic [2:0][CB-1:0]  w_in_a, w_in_b, w_in_c;

    logic                w_p_valid;
    logic [2:0][CB-1:0]  w_p_a, w_p_b, w_p_c, w_p_mab, w_p_mac, w_p_mbc;
    logic [2:0][W-1:0]   w_p_u;
    t_border             w_p_border;

    logic [PW-1:0]       w_d_pay_in, w_d_pay;
    logic                w_d_valid;
    logic [2:0][W-1:0]   w_d_quo;
    logic [2:0][CB-1:0]  w_d_a, w_d_b, w_d_c, w_d_mab, w_d_mac, w_d_mbc, w_d_ctr;
    t_border             w_d_border;

    logic [2:0][CB-1:0]  w_o_start, w_o_end;
    t_seg_kind           w_o_kind;

    assign w_in_a = {CB'(i_tri.corner_a_z), CB'(i_tri.corner_a_y), CB'(i_tri.corner_a_x)};
    assign w_in_b = {CB'(i_tri.corner_b_z), CB'(i_tri.corner_b_y), CB'(i_tri.corner_b_x)};
    assign w_in_c = {CB'(i_tri.corner_c_z), CB'(i_tri.corner_c_y), CB'(i_tri.corner_c_x)};

    assign i_tri.ready = w_en;
    assign w_en        = !w_d_valid || w_take;

    tlbe_prep #(
        .COORD_BITS (COORD_BITS),
        .LABEL_BITS (LABEL_BITS)
    ) u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (i_tri.valid),
        .i_a      (w_in_a),
        .i_b      (w_in_b),
        .i_c      (w_in_c),
        .i_la     (i_tri.label_a),
        .i_lb     (i_tri.label_b),
        .i_lc     (i_tri.label_c),
        .o_valid  (w_p_valid),
        .o_a      (w_p_a),
        .o_b      (w_p_b),
        .o_c      (w_p_c),
        .o_mab    (w_p_mab),
        .o_mac    (w_p_mac),
        .o_mbc    (w_p_mbc),
        .o_u      (w_p_u),
        .o_border (w_p_border)
    );

    assign w_d_pay_in = {w_p_a, w_p_b, w_p_c, w_p_mab, w_p_mac, w_p_mbc, w_p_border};

    tlbe_div3 #(
        .W  (W),
        .PW (PW)
    ) u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p_valid),
        .i_num   (w_p_u),
        .i_pay   (w_d_pay_in),
        .o_valid (w_d_valid),
        .o_quo   (w_d_quo),
        .o_pay   (w_d_pay)
    );

    assign {w_d_a, w_d_b, w_d_c, w_d_mab, w_d_mac, w_d_mbc} = w_d_pay[PW-1:BW];
    assign w_d_border = t_border'(w_d_pay[BW-1:0]);

    // The quotient carries the bias of half the coordinate range; removing
    // it is an inversion of the top bit, since the quotient is below 2^CB.
    for (genvar k = 0; k < 3; k++) begin : g_ctr
        assign w_d_ctr[k] = {~w_d_quo[k][CB-1], w_d_quo[k][CB-2:0]};
    end

    tlbe_emit #(
        .COORD_BITS (COORD_BITS)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_d_valid),
        .o_take   (w_take),
        .i_mesh   (r_mesh),
        .i_a      (w_d_a),
        .i_b      (w_d_b),
        .i_c      (w_d_c),
        .i_mab    (w_d_mab),
        .i_mac    (w_d_mac),
        .i_mbc    (w_d_mbc),
        .i_ctr    (w_d_ctr),
        .i_border (w_d_border),
        .o_valid  (o_seg.valid),
        .i_ready  (o_seg.ready),
        .o_start  (w_o_start),
        .o_end    (w_o_end),
        .o_kind   (w_o_kind),
        .o_last   (o_seg.last_segment)
    );

    assign o_seg.start_x      = w_o_start[0];
    assign o_seg.start_y      = w_o_start[1];
    assign o_seg.start_z      = w_o_start[2];
    assign o_seg.end_x        = w_o_end[0];
    assign o_seg.end_y        = w_o_end[1];
    assign o_seg.end_z        = w_o_end[2];
    assign o_seg.segment_kind = w_o_kind;

endmodule

`default_nettype wire
